/* hdl/masked_pixel_average_accumulator_core_macros.svh */
// Assertion helpers for the pixel averaging core.
`ifndef MASKED_PIXEL_AVERAGE_ACCUMULATOR_CORE_MACROS_SVH
`define MASKED_PIXEL_AVERAGE_ACCUMULATOR_CORE_MACROS_SVH

// same-cycle implication, checked only out of reset
`define MPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked only out of reset
`define MPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/mpa_pkg.sv */
package mpa_pkg;

  typedef enum logic {
    CMD_ACCUM = 1'b0,
    CMD_READ  = 1'b1
  } cmd_t;

  // memory port strobes
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* hdl/masked_pixel_average_accumulator_core.sv */
// Per-pixel averaging of stacked 8-bit frames, zero samples meaning no data.
// Sum, count and overflow mark of every pixel live in one synchronous memory
// word. Items are handled one at a time. An accumulate reads the memory word,
// then writes it back. A read waits on the bit-serial divider that forms
// sum*256/count (SUM_W + 8 steps); empty and out-of-range pixels skip the
// divider. After reset the memory is swept to zero, one pixel a cycle, while
// in_ready stays low. The result word sits in an output register, so a
// finished result does not hold up accumulates behind it.
`include "masked_pixel_average_accumulator_core_macros.svh"

module masked_pixel_average_accumulator_core #(
  parameter int PIXELS     = 65536,
  parameter int MAX_FRAMES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [15:0] in_pixel_addr,
  input  logic [7:0]  in_pixel_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_average,
  output logic [8:0]  out_valid_count,
  output logic        out_overflowed
);

  localparam int ADDR_W = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
  localparam int SUM_W  = $clog2(MAX_FRAMES * 255 + 1);
  localparam int DVD_W  = SUM_W + 8;

  localparam logic [24:0]      PIX_LIM = 25'(PIXELS);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAMES);

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] cnt;
    logic             ovf;
  } entry_t;

  localparam int DATA_W = $bits(entry_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_DIV,
    S_EMIT
  } state_t;

  state_t              state_r;
  mpa_pkg::cmd_t       cmd_r;
  logic [7:0]          val_r;
  logic                in_range_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [15:0]         pend_avg_r;
  logic [8:0]          pend_cnt_r;
  logic                pend_ovf_r;
  logic                out_valid_r;
  logic [15:0]         out_avg_r;
  logic [8:0]          out_cnt_r;
  logic                out_ovf_r;

  logic                in_fire;
  logic [ADDR_W+15:0]  addr_ext;
  logic [ADDR_W-1:0]   in_addr;
  logic                in_range;
  mpa_pkg::mem_ctl_t   mem_ctl;
  logic [DATA_W-1:0]   rd_word;
  entry_t              rd_ent;
  entry_t              wr_ent;
  logic                clearing;
  logic [CNT_W+8:0]    cnt_ext;
  logic                div_start;
  mpa_pkg::div_stat_t  div_stat;
  logic [DVD_W-1:0]    quotient;
  logic                emit;

  assign in_ready = (state_r == S_IDLE) && !clearing;
  assign in_fire  = in_valid && in_ready;
  assign addr_ext = (ADDR_W + 16)'(in_pixel_addr);
  assign in_addr  = addr_ext[ADDR_W-1:0];
  assign in_range = {9'b0, in_pixel_addr} < PIX_LIM;

  assign rd_ent  = entry_t'(rd_word);
  assign cnt_ext = (CNT_W + 9)'(rd_ent.cnt);

  always_comb begin
    wr_ent = rd_ent;
    if (rd_ent.cnt >= MAX_CNT) begin
      wr_ent.ovf = 1'b1;
    end else begin
      wr_ent.sum = rd_ent.sum + SUM_W'(val_r);
      wr_ent.cnt = rd_ent.cnt + 1'b1;
    end
  end

  assign mem_ctl.rd_en = in_fire;
  assign mem_ctl.wr_en = (state_r == S_RD) && (cmd_r == mpa_pkg::CMD_ACCUM)
                         && in_range_r && (val_r != 8'd0);

  assign div_start = (state_r == S_RD) && (cmd_r == mpa_pkg::CMD_READ)
                     && in_range_r && (rd_ent.cnt != '0);

  // result register free, or being drained this cycle
  assign emit = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  mpa_store #(
    .DEPTH  (PIXELS),
    .ADDR_W (ADDR_W),
    .DATA_W (DATA_W)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (mem_ctl),
    .rd_addr  (in_addr),
    .wr_addr  (addr_r),
    .wr_data  (wr_ent),
    .rd_data  (rd_word),
    .clearing (clearing)
  );

  mpa_div #(
    .DVD_W (DVD_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({rd_ent.sum, 8'd0}),
    .divisor  (rd_ent.cnt),
    .stat     (div_stat),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            cmd_r      <= mpa_pkg::cmd_t'(in_cmd);
            val_r      <= in_pixel_value;
            in_range_r <= in_range;
            addr_r     <= in_addr;
            state_r    <= S_RD;
          end
        end
        S_RD: begin
          if (cmd_r == mpa_pkg::CMD_ACCUM) begin
            state_r <= S_IDLE;
          end else if (!in_range_r) begin
            pend_avg_r <= '0;
            pend_cnt_r <= '0;
            pend_ovf_r <= 1'b0;
            state_r    <= S_EMIT;
          end else begin
            pend_avg_r <= '0;
            pend_cnt_r <= cnt_ext[8:0];
            pend_ovf_r <= rd_ent.ovf;
            state_r    <= div_start ? S_DIV : S_EMIT;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            // mean never exceeds 255.0, so the low 16 bits hold it all
            pend_avg_r <= quotient[15:0];
            state_r    <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit) begin
            out_avg_r   <= pend_avg_r;
            out_cnt_r   <= pend_cnt_r;
            out_ovf_r   <= pend_ovf_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_average     = out_avg_r;
  assign out_valid_count = out_cnt_r;
  assign out_overflowed  = out_ovf_r;

  `MPA_ASSERT_NOW(a_no_accept_in_clear, clearing, !in_ready, "word accepted during clear sweep")
  `MPA_ASSERT_NOW(a_div_done_in_div, div_stat.done, state_r == S_DIV, "divider done outside wait")
  `MPA_ASSERT_NOW(a_cnt_bound, mem_ctl.wr_en, wr_ent.cnt <= MAX_CNT, "count written past limit")
  `MPA_ASSERT_NEXT(a_div_busy_after_start, div_start, div_stat.busy, "divider failed to start")

endmodule

/* hdl/mpa_store.sv */
module mpa_store #(
  parameter int DEPTH  = 65536,
  parameter int ADDR_W = 16,
  parameter int DATA_W = 26
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mpa_pkg::mem_ctl_t     ctl,
  input  logic [ADDR_W-1:0]     rd_addr,
  input  logic [ADDR_W-1:0]     wr_addr,
  input  logic [DATA_W-1:0]     wr_data,
  output logic [DATA_W-1:0]     rd_data,
  output logic                  clearing
);

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic              clearing_r;

  // zero sweep after reset, one entry a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == LAST_ADDR) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_addr_r] <= '0;
    end else if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clearing = clearing_r;

endmodule

/* hdl/mpa_div.sv */
// Restoring divider, one quotient bit per cycle.
module mpa_div #(
  parameter int DVD_W = 24,
  parameter int DVS_W = 9
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [DVD_W-1:0]       dividend,
  input  logic [DVS_W-1:0]       divisor,
  output mpa_pkg::div_stat_t     stat,
  output logic [DVD_W-1:0]       quotient
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]  quo_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;

  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             fits;
  logic [DVS_W-1:0] rem_nxt;

  always_comb begin
    shifted = {rem_r, quo_r[DVD_W-1]};
    fits    = shifted >= {1'b0, dvs_r};
    diff    = shifted - {1'b0, dvs_r};
    // remainder stays below the divisor, so the top bit drops out
    rem_nxt = fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(DVD_W - 1);
        quo_r  <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        quo_r <= {quo_r[DVD_W-2:0], fits};
        rem_r <= rem_nxt;
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r - 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

/* dv/mpa_readback_check.sv */
module mpa_readback_check #(
  parameter int MAX_FRAMES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_cmd,
  input  logic [15:0] in_pixel_addr,
  input  logic [7:0]  in_pixel_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] out_average,
  input  logic [8:0]  out_valid_count,
  input  logic        out_overflowed,
  output int          mismatches,
  output int          awaiting
);

  typedef struct packed {
    logic [15:0] average;
    logic [8:0]  count;
    logic        dropped;
  } readback_t;

  // shadow of the per-pixel stores, starting at zero as the block's do after its clear sweep
  int unsigned pixel_sum     [65536];
  int unsigned pixel_count   [65536];
  bit          pixel_dropped [65536];
  readback_t   readback_q[$];
  int          errs = 0;

  assign mismatches = errs;

  task automatic note_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errs++;
  endtask

  task automatic stack_word(input mpa_pkg::cmd_t cmd, input logic [15:0] addr,
                            input logic [7:0] val);
    readback_t   rb;
    int unsigned n;
    if (cmd == mpa_pkg::CMD_ACCUM) begin
      if (val != 8'd0) begin
        if (pixel_count[addr] >= MAX_FRAMES) begin
          pixel_dropped[addr] = 1'b1;
        end else begin
          pixel_sum[addr]   += val;
          pixel_count[addr] += 1;
        end
      end
    end else begin
      n          = pixel_count[addr];
      rb.average = (n == 0) ? 16'd0 : 16'((pixel_sum[addr] * 256) / n);
      rb.count   = 9'(n);
      rb.dropped = pixel_dropped[addr];
      readback_q.push_back(rb);
    end
  endtask

  always @(posedge clk) begin : watch
    readback_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (readback_q.size() == 0) begin
          note_mismatch("unexpected result word, average", out_average, 0);
        end else begin
          want = readback_q.pop_front();
          if (out_average !== want.average)
            note_mismatch("average", out_average, want.average);
          if (out_valid_count !== want.count)
            note_mismatch("valid_count", out_valid_count, want.count);
          if (out_overflowed !== want.dropped)
            note_mismatch("overflowed", out_overflowed, want.dropped);
        end
      end
      if (in_valid && in_ready)
        stack_word(mpa_pkg::cmd_t'(in_cmd), in_pixel_addr, in_pixel_value);
    end
    awaiting <= readback_q.size();
  end

endmodule

/* dv/tb.sv */
module tb;

  // 64K-pixel clearing sweep plus ~1K words, with stalls
  localparam int CYCLE_LIMIT = 400000;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_cmd;
  logic [15:0] in_pixel_addr;
  logic [7:0]  in_pixel_value;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_average;
  logic [8:0]  out_valid_count;
  logic        out_overflowed;

  int          mismatches;
  int          awaiting;
  int          cycles = 0;
  int          send_gap_pct = 0;
  int          stall_pct = 0;
  logic [15:0] hot [8];

  masked_pixel_average_accumulator_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_pixel_addr  (in_pixel_addr),
    .in_pixel_value (in_pixel_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_average    (out_average),
    .out_valid_count(out_valid_count),
    .out_overflowed (out_overflowed)
  );

  mpa_readback_check u_readback_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_pixel_addr  (in_pixel_addr),
    .in_pixel_value (in_pixel_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_average    (out_average),
    .out_valid_count(out_valid_count),
    .out_overflowed (out_overflowed),
    .mismatches     (mismatches),
    .awaiting       (awaiting)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin send_gap_pct = 0;  stall_pct = 0;  end
      IDLE_SEND: begin send_gap_pct = 66; stall_pct = 0;  end
      IDLE_RECV: begin send_gap_pct = 0;  stall_pct = 66; end
      default:   begin send_gap_pct = 11; stall_pct = 11; end
    endcase
  endtask

  // valid stays high across back-to-back words; dropped only for a gap
  task automatic send_word(input mpa_pkg::cmd_t cmd, input logic [15:0] addr,
                           input logic [7:0] val);
    int gap = 0;
    while ($urandom_range(99) < send_gap_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_cmd         <= cmd;
    in_pixel_addr  <= addr;
    in_pixel_value <= val;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
  endtask

  task automatic random_word();
    int            r;
    mpa_pkg::cmd_t cmd;
    logic [15:0]   addr;
    logic [7:0]    val;
    r = $urandom_range(99);
    if (r < 15) begin
      addr = 16'($urandom);
      cmd  = mpa_pkg::cmd_t'($urandom_range(1));
    end else begin
      addr = hot[$urandom_range(7)];
      cmd  = (r < 40) ? mpa_pkg::CMD_READ : mpa_pkg::CMD_ACCUM;
    end
    val = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(255, 1));
    send_word(cmd, addr, val);
  endtask

  // drive one pixel past the frame limit, peeking along the way
  task automatic saturate_pixel(input logic [15:0] addr, input int n, input bit full_scale);
    for (int i = 0; i < n; i++) begin
      send_word(mpa_pkg::CMD_ACCUM, addr, full_scale ? 8'hFF : 8'($urandom_range(255, 1)));
      if (i % 64 == 63) send_word(mpa_pkg::CMD_READ, addr, 8'($urandom));
    end
    send_word(mpa_pkg::CMD_ACCUM, addr, 8'd0);
    send_word(mpa_pkg::CMD_READ, addr, 8'($urandom));
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_cmd         = mpa_pkg::CMD_ACCUM;
    in_pixel_addr  = 16'd0;
    in_pixel_value = 8'd0;
    set_idle(IDLE_NONE);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty pixel, zero sample, address and value extremes
    send_word(mpa_pkg::CMD_READ,  16'h0000, 8'h00);
    send_word(mpa_pkg::CMD_ACCUM, 16'h0000, 8'h00);
    send_word(mpa_pkg::CMD_READ,  16'h0000, 8'hFF);
    send_word(mpa_pkg::CMD_ACCUM, 16'hFFFF, 8'hFF);
    send_word(mpa_pkg::CMD_ACCUM, 16'hFFFF, 8'h01);
    send_word(mpa_pkg::CMD_READ,  16'hFFFF, 8'h00);
    send_word(mpa_pkg::CMD_ACCUM, 16'hFFFF, 8'h00);
    send_word(mpa_pkg::CMD_READ,  16'hFFFF, 8'h00);
    send_word(mpa_pkg::CMD_ACCUM, 16'h0000, 8'h80);
    send_word(mpa_pkg::CMD_ACCUM, 16'h0000, 8'h7F);
    send_word(mpa_pkg::CMD_ACCUM, 16'h0000, 8'h01);
    send_word(mpa_pkg::CMD_READ,  16'h0000, 8'h00);
    send_word(mpa_pkg::CMD_ACCUM, 16'h5555, 8'hAA);
    send_word(mpa_pkg::CMD_ACCUM, 16'hAAAA, 8'h55);
    send_word(mpa_pkg::CMD_READ,  16'h5555, 8'h55);
    send_word(mpa_pkg::CMD_READ,  16'hAAAA, 8'hAA);
    send_word(mpa_pkg::CMD_ACCUM, 16'h8000, 8'h03);
    send_word(mpa_pkg::CMD_ACCUM, 16'h8000, 8'h03);
    send_word(mpa_pkg::CMD_ACCUM, 16'h8000, 8'h03);
    send_word(mpa_pkg::CMD_READ,  16'h8000, 8'h00);
    send_word(mpa_pkg::CMD_ACCUM, 16'h8000, 8'h01);
    send_word(mpa_pkg::CMD_READ,  16'h8000, 8'h00);
    send_word(mpa_pkg::CMD_READ,  16'h7FFF, 8'h00);

    // hold off until the directed reads are all back
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      set_idle(idle_mode_t'(phase));
      foreach (hot[i]) hot[i] = 16'($urandom);
      if (phase == 2) hot[0] = 16'hFFFF;
      if (phase == 1) saturate_pixel(16'($urandom), 260, 1'b1);
      if (phase == 3) saturate_pixel(16'($urandom), 262, 1'b0);
      repeat (130) random_word();
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && awaiting == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
